// ===== design/assert_macros.svh =====
// assertion macros for the base64url encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when cond holds, expr must hold in the next cycle
`define ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== design/b64u_pkg.sv =====
// shared types, constants and alphabet lookup for the base64url encoder
`default_nettype none

package b64u_pkg;

  localparam logic [6:0] PadChar = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } grp_t;

  function automatic logic [6:0] b64u_sym(input logic [5:0] v);
    logic [6:0] ch;
    ch = 7'h3F;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 7'h2D;
    end else begin
      ch = 7'h5F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64u_pack.sv =====
// byte gathering and group encoding into a registered character group
`default_nettype none

module b64u_pack (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic pad_enable,
  input  wire                logic in_valid,
  output                     logic in_ready,
  input  wire  b64u_pkg::in_t      in_data,
  output                     logic grp_valid,
  input  wire                logic grp_take,
  output       b64u_pkg::grp_t     grp
);
  import b64u_pkg::*;

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        grp_valid_r, grp_valid_nxt;
  grp_t        grp_r, grp_nxt;
  logic [1:0]  ph;
  logic        accept;
  logic        closes;
  logic [7:0]  b0, b1, b2;
  logic [5:0]  s0, s1, s2, s3;

  assign in_ready  = !grp_valid_r || grp_take;
  assign accept    = in_valid && in_ready;
  assign grp_valid = grp_valid_r;
  assign grp       = grp_r;

  always_comb begin
    ph     = (phase_r == 2'd3) ? 2'd0 : phase_r;
    closes = in_data.last_byte || (ph == 2'd2);
    b0 = (ph == 2'd0) ? in_data.data_byte : pend_r[15:8];
    b1 = (ph == 2'd0) ? 8'h00 : ((ph == 2'd1) ? in_data.data_byte : pend_r[7:0]);
    b2 = (ph == 2'd2) ? in_data.data_byte : 8'h00;
    s0 = b0[7:2];
    s1 = {b0[1:0], b1[7:4]};
    s2 = {b1[3:0], b2[7:6]};
    s3 = b2[5:0];

    grp_nxt.chars[0] = b64u_sym(s0);
    grp_nxt.chars[1] = b64u_sym(s1);
    grp_nxt.chars[2] = (ph != 2'd0) ? b64u_sym(s2) : PadChar;
    grp_nxt.chars[3] = (ph == 2'd2) ? b64u_sym(s3) : PadChar;
    grp_nxt.last_idx = (pad_enable || (ph == 2'd2)) ? 2'd3 : ph + 2'd1;
    grp_nxt.fin      = in_data.last_byte;
  end

  always_comb begin
    pend_nxt      = pend_r;
    phase_nxt     = phase_r;
    grp_valid_nxt = grp_take ? 1'b0 : grp_valid_r;
    if (accept) begin
      if (closes) begin
        pend_nxt      = 16'h0000;
        phase_nxt     = 2'd0;
        grp_valid_nxt = 1'b1;
      end else if (ph == 2'd0) begin
        pend_nxt  = {in_data.data_byte, 8'h00};
        phase_nxt = 2'd1;
      end else begin
        pend_nxt  = {pend_r[15:8], in_data.data_byte};
        phase_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 16'h0000;
      phase_r     <= 2'd0;
      grp_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      phase_r     <= phase_nxt;
      grp_valid_r <= grp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && closes) begin
      grp_r <= grp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64u_serial.sv =====
// character serializer: one encoded character per output transaction
`default_nettype none

module b64u_serial (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic grp_valid,
  output                      logic grp_take,
  input  wire  b64u_pkg::grp_t      grp,
  output                      logic out_valid,
  input  wire                 logic out_ready,
  output       b64u_pkg::out_t      out_data
);
  import b64u_pkg::*;

  `include "assert_macros.svh"

  logic            busy_r, busy_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [3:0][6:0] chars_r;
  logic [1:0]      last_idx_r;
  logic            fin_r;
  logic            at_end;

  assign at_end    = (idx_r == last_idx_r);
  assign grp_take  = grp_valid && (!busy_r || (out_ready && at_end));
  assign out_valid = busy_r;
  assign out_data.out_char  = chars_r[idx_r];
  assign out_data.last_char = fin_r && at_end;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (grp_take) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (busy_r && out_ready) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      chars_r    <= grp.chars;
      last_idx_r <= grp.last_idx;
      fin_r      <= grp.fin;
    end
  end

  `ASSERT_NEXT(a_stall_holds, busy_r && !out_ready, busy_r && $stable(idx_r), "stall lost char")
  `ASSERT_NEXT(a_group_cont, busy_r && out_ready && !at_end,
               busy_r && (idx_r == $past(idx_r) + 2'd1), "group cut short")
  `ASSERT_ALWAYS(a_pad_tail, !(busy_r && (out_data.out_char == PadChar)) || (idx_r[1] == 1'b1),
                 "padding in first two positions")
  `ASSERT_ALWAYS(a_min_chars, !busy_r || (last_idx_r != 2'd0), "group shorter than two chars")

endmodule

`default_nettype wire

// ===== design/base64url_encoder.sv =====
// Streaming base64url encoder: one byte per input transaction, one char per output transaction.
// The closing byte is registered in the pack group register, then in the serializer registers.
// Throughput: one character per cycle while out_ready is high; a byte is taken every cycle
// while the group register is free or being drained, and any byte waits while it is full. The
// rate is set by the single-character output port draining each group.
// Synchronous active-low reset clears pending bytes, phase, valids and pad_enable.
`default_nettype none

module base64url_encoder (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic cfg_wr_en,
  input  wire                 logic cfg_wr_data,
  input  wire                 logic in_valid,
  output                      logic in_ready,
  input  wire  b64u_pkg::in_t       in_data,
  output                      logic out_valid,
  input  wire                 logic out_ready,
  output       b64u_pkg::out_t      out_data
);
  import b64u_pkg::*;

  logic pad_enable_r, pad_enable_nxt;
  logic grp_valid;
  logic grp_take;
  grp_t grp;

  assign pad_enable_nxt = cfg_wr_en ? cfg_wr_data : pad_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_enable_r <= 1'b0;
    end else begin
      pad_enable_r <= pad_enable_nxt;
    end
  end

  b64u_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .pad_enable (pad_enable_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .grp_valid  (grp_valid),
    .grp_take   (grp_take),
    .grp        (grp)
  );

  b64u_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_take  (grp_take),
    .grp       (grp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/base64url_encoder_checker.sv =====
// checker for the base64url encoder: watches both channels, predicts characters, compares
`default_nettype none

module base64url_encoder_checker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire b64u_pkg::in_t   in_data,
  input  wire logic            out_valid,
  input  wire logic            out_ready,
  input  wire b64u_pkg::out_t  out_data,
  output int unsigned          chars_outstanding,
  output int unsigned          fail_count
);
  import b64u_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*64-1:0] UrlAlphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic        pad_on;
  logic [15:0] held_bytes;
  logic [1:0]  bytes_held;
  out_t        expected_chars[$];
  out_t        oldest;

  function automatic logic [6:0] url_char(input logic [5:0] idx);
    return UrlAlphabet[8*(63 - int'(idx)) +: 7];
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic fin);
    out_t item;
    item.out_char  = ch;
    item.last_char = fin;
    expected_chars.push_back(item);
  endfunction

  function automatic void encode_byte(input in_t item);
    logic [1:0] phase;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [6:0] syms [4];
    int         nbytes;
    int         total;
    phase = (bytes_held == 2'd3) ? 2'd0 : bytes_held;
    if (phase < 2'd2 && !item.last_byte) begin
      if (phase == 2'd0) held_bytes = {item.data_byte, 8'h00};
      else held_bytes[7:0] = item.data_byte;
      bytes_held = phase + 2'd1;
      return;
    end
    b0 = (phase == 2'd0) ? item.data_byte : held_bytes[15:8];
    b1 = (phase == 2'd0) ? 8'h00 : (phase == 2'd1) ? item.data_byte : held_bytes[7:0];
    b2 = (phase == 2'd2) ? item.data_byte : 8'h00;
    syms[0] = url_char(b0[7:2]);
    syms[1] = url_char({b0[1:0], b1[7:4]});
    syms[2] = url_char({b1[3:0], b2[7:6]});
    syms[3] = url_char(b2[5:0]);
    nbytes = int'(phase) + 1;
    total  = (nbytes < 3 && pad_on) ? 4 : nbytes + 1;
    for (int k = 0; k < total; k++)
      push_char((k < nbytes + 1) ? syms[k] : PadChar, item.last_byte && (k == total - 1));
    held_bytes = '0;
    bytes_held = '0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pad_on     = 1'b0;
      held_bytes = '0;
      bytes_held = '0;
      fail_count = 0;
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char expected none actual %h", out_data.out_char);
          fail_count++;
        end else begin
          oldest = expected_chars.pop_front();
          if (out_data.out_char !== oldest.out_char) begin
            $error("out_char expected %h actual %h", oldest.out_char, out_data.out_char);
            fail_count++;
          end
          if (out_data.last_char !== oldest.last_char) begin
            $error("last_char expected %b actual %b", oldest.last_char, out_data.last_char);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) encode_byte(in_data);
      if (cfg_wr_en) pad_on = cfg_wr_data;
    end
    chars_outstanding <= expected_chars.size();
  end

endmodule

`default_nettype wire

// ===== tb/base64url_encoder_tb.sv =====
// testbench top for the base64url encoder: byte stimulus, pad settings, idle phases, verdict
`default_nettype none

module base64url_encoder_tb;
  import b64u_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_t         in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_t        out_data;
  int unsigned chars_outstanding;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int          sender_idle_pct = 0;
  int          recv_idle_pct   = 0;

  base64url_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  base64url_encoder_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .chars_outstanding(chars_outstanding),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready   <= ($urandom_range(99) >= recv_idle_pct);
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("base64url_encoder regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= {data, last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_message_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_pad(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random_messages(input int byte_budget);
    int sent;
    int len;
    sent = 0;
    while (sent < byte_budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom_range(255)), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unpadded: one, two, three and four byte messages, zero and all-ones bytes
    write_pad(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_message_stream();

    // padded partial groups
    write_pad(1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b1);
    drain_message_stream();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin sender_idle_pct = 61; recv_idle_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_idle_pct = 61; end
        default: begin sender_idle_pct = 12; recv_idle_pct = 12; end
      endcase
      write_pad(phase == 1 || phase == 2);
      send_random_messages(20);
      drain_message_stream();
    end

    if (fail_count == 0) begin
      $display("base64url_encoder regression: pass");
    end else begin
      $display("base64url_encoder regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/b64u_pkg.sv
design/b64u_pack.sv
design/b64u_serial.sv
design/base64url_encoder.sv
tb/base64url_encoder_checker.sv
tb/base64url_encoder_tb.sv
